FILE: rtl/core/iamc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iamc_pkg
// Shared types, character codes, the ambiguity-code cover function and
// the column mismatch function for the IUPAC-aware mismatch counter.
// ----------------------------------------------------------------------------
package iamc_pkg;

    localparam int BASE_W = 8;
    localparam int OUT_W  = 16;

    typedef logic [BASE_W-1:0] t_base;
    typedef logic [OUT_W-1:0]  t_out_count;

    localparam t_base CH_N    = "N";
    localparam t_base CH_GAP  = "-";
    localparam t_base CH_DOT  = ".";
    localparam t_base CH_A    = "A";
    localparam t_base CH_C    = "C";
    localparam t_base CH_G    = "G";
    localparam t_base CH_T    = "T";
    localparam t_base CH_Y    = "Y";
    localparam t_base CH_R    = "R";
    localparam t_base CH_S    = "S";
    localparam t_base CH_W    = "W";
    localparam t_base CH_M    = "M";
    localparam t_base CH_K    = "K";
    localparam t_base CH_V    = "V";
    localparam t_base CH_H    = "H";
    localparam t_base CH_D    = "D";
    localparam t_base CH_B    = "B";

    // true when ambiguity code covers the plain base
    function automatic logic code_covers(input t_base code, input t_base base);
        logic is_a, is_c, is_g, is_t, res;
        is_a = (base == CH_A);
        is_c = (base == CH_C);
        is_g = (base == CH_G);
        is_t = (base == CH_T);
        case (code)
            CH_Y: res = is_c | is_t;
            CH_R: res = is_g | is_a;
            CH_S: res = is_c | is_g;
            CH_W: res = is_t | is_a;
            CH_M: res = is_a | is_c;
            CH_K: res = is_t | is_g;
            CH_V: res = is_c | is_a | is_g;
            CH_H: res = is_t | is_a | is_c;
            CH_D: res = is_t | is_a | is_g;
            CH_B: res = is_c | is_t | is_g;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic column_mismatch(input t_base a, input t_base b);
        logic equiv;
        equiv = ((a == CH_N) && (b != CH_GAP)) || ((b == CH_N) && (a != CH_GAP)) ||
                code_covers(a, b) || code_covers(b, a) ||
                ((a == CH_DOT) && (b == CH_GAP)) || ((b == CH_DOT) && (a == CH_GAP));
        return (a != b) && !equiv;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/iamc_col_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iamc_col_if
// Column channel: one byte of each aligned sequence plus the last flag.
// ----------------------------------------------------------------------------
interface iamc_col_if;
    import iamc_pkg::*;

    logic  valid;
    logic  ready;
    t_base base_a;
    t_base base_b;
    logic  last_column;

    modport source (output valid, output base_a, output base_b, output last_column,
                    input ready);
    modport sink   (input valid, input base_a, input base_b, input last_column,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iamc_cnt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iamc_cnt_if
// Result channel: mismatch total of one compared pair.
// ----------------------------------------------------------------------------
interface iamc_cnt_if;
    import iamc_pkg::*;

    logic       valid;
    logic       ready;
    t_out_count mismatch_count;

    modport source (output valid, output mismatch_count, input ready);
    modport sink   (input valid, input mismatch_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iupac_aware_mismatch_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iupac_aware_mismatch_counter
// Counts non-equivalent differing columns of two aligned sequences.
// ----------------------------------------------------------------------------
// Takes one column beat per cycle. Each beat is registered, classified by a
// small compare table (N wildcard, two- and three-base ambiguity codes, dot
// against gap) and added to a saturating counter of COUNT_WIDTH bits. The
// beat flagged last_column produces one result beat holding the total
// (low 16 bits) and clears the counter. A last beat passes the column
// register, then the result register. One column is accepted every cycle;
// the input only stalls when a last column waits behind an untaken result.
module iupac_aware_mismatch_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    iamc_col_if.sink        i_col,
    iamc_cnt_if.source      o_cnt
);
    import iamc_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // column register
    logic   r_s1_valid;
    t_base  r_s1_a;
    t_base  r_s1_b;
    logic   r_s1_last;

    t_count     r_count;
    t_count     n_count;
    logic       r_out_valid;
    t_out_count r_out_count;
    t_out_count n_out_count;

    logic s1_advance;
    logic s1_mismatch;

    // non-last beats never need the result register
    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || o_cnt.ready);
    assign i_col.ready = !r_s1_valid || s1_advance;

    assign s1_mismatch = column_mismatch(r_s1_a, r_s1_b);

    always_comb begin
        n_count = r_count;
        if (s1_mismatch && (r_count != {COUNT_WIDTH{1'b1}})) begin
            n_count = r_count + t_count'(1);
        end
    end

    generate
        if (COUNT_WIDTH >= OUT_W) begin : g_trunc
            assign n_out_count = n_count[OUT_W-1:0];
        end else begin : g_ext
            assign n_out_count = {{(OUT_W-COUNT_WIDTH){1'b0}}, n_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_col.valid && i_col.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_advance) begin
                r_count <= r_s1_last ? '0 : n_count;
            end

            if (s1_advance && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_cnt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_col.valid && i_col.ready) begin
            r_s1_a    <= i_col.base_a;
            r_s1_b    <= i_col.base_b;
            r_s1_last <= i_col.last_column;
        end
        if (s1_advance && r_s1_last) begin
            r_out_count <= n_out_count;
        end
    end

    assign o_cnt.valid          = r_out_valid;
    assign o_cnt.mismatch_count = r_out_count;

endmodule
`default_nettype wire

FILE: rtl/core/iamc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iamc_checker
// Port-level checks of the mismatch counter, bound to the top level.
// ----------------------------------------------------------------------------
module iamc_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  wire                  i_in_last,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  iamc_pkg::t_out_count i_out_count
);
    import iamc_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_count)))
        else $error("result beat changed while stalled");

    // a new result follows an accepted last column via the column and result registers
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("result beat without a last column");

    // input only stalls while a result waits
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("column input stalled with free result path");

    // no result right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result beat right after reset");

endmodule

bind iupac_aware_mismatch_counter iamc_checker u_iamc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_col.valid),
    .i_in_ready  (i_col.ready),
    .i_in_last   (i_col.last_column),
    .i_out_valid (o_cnt.valid),
    .i_out_ready (o_cnt.ready),
    .i_out_count (o_cnt.mismatch_count)
);
`default_nettype wire

FILE: bench/tb_iupac_aware_mismatch_counter.sv
// ----------------------------------------------------------------------------
// tb_iupac_aware_mismatch_counter
// Self-checking bench for the IUPAC-aware column mismatch counter.
// ----------------------------------------------------------------------------
// Streams column beats (two sequence bytes and a last flag) into the block
// and checks every total that comes out against a tally kept in the bench.
// The tally applies the wildcard, ambiguity-code and dot/gap rules,
// saturates, and queues one total per pair. The stimulus has a short
// directed set, one long all-mismatch pair, and random pairs. Random gaps
// on both sides, one long hold on the result side and one full drain on
// the column side shape the flow.
// ----------------------------------------------------------------------------
module tb_iupac_aware_mismatch_counter;
    import iamc_pkg::*;

    localparam int COUNT_W      = 16;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int LONG_COLUMNS = 200;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 500;
    localparam int SETTLE       = 8;

    // running tally of one compared pair and the totals still owed
    class column_tally;
        logic [COUNT_W-1:0] run_count;
        t_out_count         totals_due[$];
        int                 errors;

        function new();
            run_count = '0;
            errors    = 0;
        endfunction

        function bit covers(t_base code, t_base base);
            case (code)
                CH_Y: return base inside {CH_C, CH_T};
                CH_R: return base inside {CH_G, CH_A};
                CH_S: return base inside {CH_C, CH_G};
                CH_W: return base inside {CH_T, CH_A};
                CH_M: return base inside {CH_A, CH_C};
                CH_K: return base inside {CH_T, CH_G};
                CH_V: return base inside {CH_C, CH_A, CH_G};
                CH_H: return base inside {CH_T, CH_A, CH_C};
                CH_D: return base inside {CH_T, CH_A, CH_G};
                CH_B: return base inside {CH_C, CH_T, CH_G};
                default: return 1'b0;
            endcase
        endfunction

        function bit is_counted(t_base a, t_base b);
            if (a == b)
                return 1'b0;
            // wildcard matches anything except a gap
            if ((a == CH_N && b != CH_GAP) || (b == CH_N && a != CH_GAP))
                return 1'b0;
            if (covers(a, b) || covers(b, a))
                return 1'b0;
            if ((a == CH_DOT && b == CH_GAP) || (a == CH_GAP && b == CH_DOT))
                return 1'b0;
            return 1'b1;
        endfunction

        function void take_column(t_base a, t_base b, logic last);
            if (is_counted(a, b) && run_count != {COUNT_W{1'b1}})
                run_count++;
            if (last) begin
                totals_due = {totals_due, t_out_count'(run_count)};
                run_count = '0;
            end
        endfunction

        function void check_total(t_out_count got);
            t_out_count want;
            if (totals_due.size() == 0) begin
                $error("mismatch_count: no total expected, got %0d", got);
                errors++;
                return;
            end
            want = totals_due.pop_front();
            if (got !== want) begin
                $error("mismatch_count: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return totals_due.size();
        endfunction
    endclass

    typedef struct packed {
        t_base a;
        t_base b;
        logic  last;
    } t_col_beat;

    logic clk;
    logic rst_n;

    iamc_col_if col_bus ();
    iamc_cnt_if cnt_bus ();

    column_tally tally = new();

    int send_max_gap  = 0;
    int rcv_max_stall = 0;
    bit long_hold_req = 1'b0;

    iupac_aware_mismatch_counter #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_col  (col_bus),
        .o_cnt  (cnt_bus)
    );

    always begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // beat monitor: feeds the tally and checks totals
    always @(posedge clk) begin
        if (rst_n) begin
            if (col_bus.valid && col_bus.ready)
                tally.take_column(col_bus.base_a, col_bus.base_b, col_bus.last_column);
            if (cnt_bus.valid && cnt_bus.ready)
                tally.check_total(cnt_bus.mismatch_count);
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        cnt_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (long_hold_req) begin
                cnt_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, rcv_max_stall);
                if (stall > 0) begin
                    cnt_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            cnt_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(cnt_bus.valid && cnt_bus.ready));
        end
    end

    function automatic int column_gap();
        return $urandom_range(0, send_max_gap);
    endfunction

    // mostly nucleotide and ambiguity letters, some lower case, some raw bytes
    function automatic t_base pick_byte();
        string alphabet;
        int    r;
        alphabet = "ACGTNYRSWMKVHDB-.";
        r = $urandom_range(0, 9);
        if (r < 6)
            return t_base'(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        if (r < 8)
            return t_base'(alphabet[$urandom_range(0, alphabet.len() - 1)]) | 8'h20;
        return t_base'($urandom_range(0, 255));
    endfunction

    task automatic send_column(input t_base a, input t_base b, input logic last,
                               input int gap);
        if (gap > 0) begin
            col_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        col_bus.valid       <= 1'b1;
        col_bus.base_a      <= a;
        col_bus.base_b      <= b;
        col_bus.last_column <= last;
        do
            @(posedge clk);
        while (!col_bus.ready);
    endtask

    // the monitor has seen the last beat only after the next edge
    task automatic wait_totals_done();
        @(posedge clk);
        while (tally.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_pairs(input int count);
        int    sent;
        int    len;
        int    next_phase;
        t_base a;
        t_base b;
        sent       = 0;
        next_phase = 0;
        while (sent < count) begin
            if (sent >= next_phase) begin
                case ($urandom_range(0, 2))
                    0: send_max_gap = 0;
                    1: send_max_gap = 17;
                    default: send_max_gap = 4;
                endcase
                case ($urandom_range(0, 2))
                    0: rcv_max_stall = 0;
                    1: rcv_max_stall = 17;
                    default: rcv_max_stall = 4;
                endcase
                next_phase += 150;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                a = pick_byte();
                b = ($urandom_range(0, 3) == 0) ? a : pick_byte();
                send_column(a, b, i == len - 1, column_gap());
                sent++;
            end
        end
    endtask

    initial begin
        t_col_beat directed[$];
        int        settle;

        rst_n               <= 1'b0;
        col_bus.valid       <= 1'b0;
        col_bus.base_a      <= '0;
        col_bus.base_b      <= '0;
        col_bus.last_column <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // byte extremes, wildcard against gap, two codes, codes against bases, dot/gap, case
        directed = '{
            '{8'h00,   8'hFF,   1'b1},
            '{8'hFF,   8'hFF,   1'b1},
            '{CH_N,    CH_GAP,  1'b0},
            '{CH_GAP,  CH_N,    1'b0},
            '{CH_N,    CH_Y,    1'b0},
            '{CH_Y,    CH_N,    1'b0},
            '{CH_Y,    CH_R,    1'b0},
            '{CH_DOT,  CH_GAP,  1'b0},
            '{CH_GAP,  CH_DOT,  1'b0},
            '{"a",     CH_A,    1'b0},
            '{"n",     CH_C,    1'b0},
            '{CH_N,    CH_N,    1'b0},
            '{CH_GAP,  CH_GAP,  1'b1},
            '{CH_V,    CH_T,    1'b0},
            '{CH_A,    CH_B,    1'b0},
            '{CH_H,    CH_C,    1'b0},
            '{CH_G,    CH_D,    1'b0},
            '{CH_DOT,  CH_N,    1'b0},
            '{CH_K,    CH_T,    1'b0},
            '{CH_DOT,  CH_A,    1'b1}
        };
        send_max_gap  = 3;
        rcv_max_stall = 3;
        foreach (directed[i])
            send_column(directed[i].a, directed[i].b, directed[i].last, column_gap());

        // one long pair where every column counts, then a short pair to see
        // the counter cleared
        send_max_gap  = 0;
        rcv_max_stall = 17;
        for (int i = 0; i < LONG_COLUMNS; i++)
            send_column(CH_A, CH_T, i == LONG_COLUMNS - 1, 0);
        send_column(CH_S, CH_T, 1'b1, 0);

        send_random_pairs(RANDOM_ITEMS);

        // result side holds off while short pairs keep coming
        send_max_gap  = 0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 120; i++)
            send_column(pick_byte(), pick_byte(), (i % 3) == 2, 0);

        // column side pauses until every total is back
        col_bus.valid <= 1'b0;
        wait_totals_done();

        send_random_pairs(RANDOM_ITEMS);

        col_bus.valid <= 1'b0;
        wait_totals_done();
        settle = SETTLE;
        repeat (settle) @(posedge clk);

        if (tally.errors == 0 && tally.pending() == 0) begin
            $display("iupac_aware_mismatch_counter verification clean");
        end else begin
            $display("iupac_aware_mismatch_counter verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("iupac_aware_mismatch_counter verification failed");
        $finish;
    end

endmodule

FILE: iupac_aware_mismatch_counter.f
rtl/core/iamc_pkg.sv
rtl/core/iamc_col_if.sv
rtl/core/iamc_cnt_if.sv
rtl/core/iupac_aware_mismatch_counter.sv
rtl/core/iamc_checker.sv
bench/tb_iupac_aware_mismatch_counter.sv
